FILE: design/kvbfd_pkg.sv
// shared types and constants for the binary request-frame deframer
package kvbfd_pkg;

	// byte tags reported with each byte
	typedef enum logic [2:0] {
		CLS_COMMAND = 3'd0,
		CLS_TERM_PAD = 3'd1,
		CLS_KEY_LEN = 3'd2,
		CLS_VAL_LEN = 3'd3,
		CLS_KEY = 3'd4,
		CLS_VALUE = 3'd5,
		CLS_TRAIL = 3'd6
	} byte_class_t;

	// token counts reported with each result; nonzero only at the end of a good frame
	localparam logic [1:0] TOKENS_NONE = 2'd0;
	localparam logic [1:0] TOKENS_KEY_ONLY = 2'd2;
	localparam logic [1:0] TOKENS_KEY_VALUE = 2'd3;

	// reset value of the minimum command block size
	localparam logic [4:0] MIN_BLOCK_RESET = 5'd4;

	// one tagged result
	typedef struct packed {
		logic [7:0] byte_value;
		byte_class_t byte_class;
		logic frame_end;
		logic frame_ok;
		logic [1:0] token_count;
	} result_t;

endpackage

FILE: design/kvbfd_parser.sv
// frame parsing state and per-byte tagging logic
module kvbfd_parser (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic [4:0] min_block,
	output kvbfd_pkg::result_t result
);
	import kvbfd_pkg::*;

	typedef enum logic [7:0] {
		PH_CMD = 8'b0000_0001,
		PH_PAD = 8'b0000_0010,
		PH_KLEN = 8'b0000_0100,
		PH_VLEN = 8'b0000_1000,
		PH_KEY = 8'b0001_0000,
		PH_VAL = 8'b0010_0000,
		PH_TRAIL = 8'b0100_0000,
		PH_REJECT = 8'b1000_0000
	} phase_t;

	phase_t phase_q, phase_d;
	logic [4:0] block_seen_q, block_seen_d, block_inc;
	logic [1:0] len_idx_q, len_idx_d;
	logic [31:0] key_len_q, key_len_d, key_shift;
	logic [31:0] val_len_q, val_len_d, val_shift;
	logic [30:0] left_q, left_d, left_dec;
	byte_class_t cls;
	logic ok;

	// saturating block count, shifted lengths, body countdown
	assign block_inc = (block_seen_q == 5'd31) ? block_seen_q : block_seen_q + 5'd1;
	assign key_shift = {key_len_q[23:0], data_byte};
	assign val_shift = {val_len_q[23:0], data_byte};
	assign left_dec = (left_q != '0) ? left_q - 31'd1 : left_q;

	// next state and byte tag
	always_comb begin
		phase_d = phase_q;
		block_seen_d = block_seen_q;
		len_idx_d = len_idx_q;
		key_len_d = key_len_q;
		val_len_d = val_len_q;
		left_d = left_q;
		cls = CLS_TRAIL;
		unique case (phase_q) inside
			PH_CMD: begin
				cls = (data_byte == 8'd0) ? CLS_TERM_PAD : CLS_COMMAND;
				block_seen_d = block_inc;
				if (data_byte == 8'd0) begin
					phase_d = (block_inc >= min_block) ? PH_KLEN : PH_PAD;
				end
			end
			PH_PAD: begin
				cls = CLS_TERM_PAD;
				block_seen_d = block_inc;
				if (block_inc >= min_block) begin
					phase_d = PH_KLEN;
				end
			end
			PH_KLEN: begin
				cls = CLS_KEY_LEN;
				key_len_d = key_shift;
				len_idx_d = len_idx_q + 2'd1;
				if (len_idx_q == 2'd3) begin
					phase_d = PH_VLEN;
				end
			end
			PH_VLEN: begin
				cls = CLS_VAL_LEN;
				val_len_d = val_shift;
				len_idx_d = len_idx_q + 2'd1;
				if (len_idx_q == 2'd3) begin
					if (key_len_q[31] || val_shift[31]) begin
						phase_d = PH_REJECT;
					end else if (key_len_q != '0) begin
						left_d = key_len_q[30:0];
						phase_d = PH_KEY;
					end else if (val_shift != '0) begin
						left_d = val_shift[30:0];
						phase_d = PH_VAL;
					end else begin
						phase_d = PH_TRAIL;
					end
				end
			end
			PH_KEY: begin
				cls = CLS_KEY;
				left_d = left_dec;
				if (left_dec == '0) begin
					if (val_len_q != '0) begin
						left_d = val_len_q[30:0];
						phase_d = PH_VAL;
					end else begin
						phase_d = PH_TRAIL;
					end
				end
			end
			PH_VAL: begin
				cls = CLS_VALUE;
				left_d = left_dec;
				if (left_dec == '0) begin
					phase_d = PH_TRAIL;
				end
			end
			PH_TRAIL, PH_REJECT: begin
				cls = CLS_TRAIL;
			end
			default: begin
				cls = CLS_TRAIL;
			end
		endcase
	end

	// frame verdict on the last byte
	assign ok = last_byte && (phase_d == PH_TRAIL);
	always_comb begin
		result.byte_value = data_byte;
		result.byte_class = cls;
		result.frame_end = last_byte;
		result.frame_ok = ok;
		result.token_count = !ok ? TOKENS_NONE :
			(val_len_d != '0) ? TOKENS_KEY_VALUE : TOKENS_KEY_ONLY;
	end

	// state update, cleared after every frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			block_seen_q <= '0;
			len_idx_q <= '0;
			key_len_q <= '0;
			val_len_q <= '0;
			left_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				phase_q <= PH_CMD;
				block_seen_q <= '0;
				len_idx_q <= '0;
				key_len_q <= '0;
				val_len_q <= '0;
				left_q <= '0;
			end else begin
				phase_q <= phase_d;
				block_seen_q <= block_seen_d;
				len_idx_q <= len_idx_d;
				key_len_q <= key_len_d;
				val_len_q <= val_len_d;
				left_q <= left_d;
			end
		end
	end

endmodule

FILE: design/kv_binary_frame_deframer_core.sv
// top level of the binary request-frame deframer
// Tags each byte of a request frame with its role: command, terminator or pad,
// key length, value length, key, value or trailing. Input transactions carry
// data_byte and last_byte on in_valid/in_stall; each produces exactly one
// output transaction on out_valid/out_stall with the byte, its tag and, on the
// frame's last byte, frame_ok and token_count. Tags are issued before the
// frame's verdict is known, so a consumer drops the bytes of a failed frame.
// Throughput is one byte per cycle while in_stall is low. The frame parser is
// one pass of logic into the output register, or into the skid register while
// the output register is held. A two-entry output buffer (output register
// plus skid register) keeps input open while one result waits: in_stall
// rises only when both entries are full, and comes from a register.
// min_command_block is written over cfg_valid/cfg_ready (always ready) and
// must only change between frames while the block is idle.
// Reset clears the parser to the start of a frame, empties the output buffer
// and sets min_command_block to 4.
module kv_binary_frame_deframer_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [7:0] byte_value,
	output logic [2:0] byte_class,
	output logic frame_end,
	output logic frame_ok,
	output logic [1:0] token_count,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [4:0] cfg_data
);
	import kvbfd_pkg::*;

	logic [4:0] min_block_q;
	logic in_acc, out_take;
	result_t res;
	result_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_block_q <= MIN_BLOCK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			min_block_q <= cfg_data;
		end
	end

	// handshakes
	assign in_stall = skid_valid_q;
	assign in_acc = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	kvbfd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.accept(in_acc),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.min_block(min_block_q),
		.result(res)
	);

	// output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_acc;
				end
			end else if (in_acc) begin
				if (!out_valid_q) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			if (!out_valid_q) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// output ports
	assign out_valid = out_valid_q;
	assign byte_value = out_q.byte_value;
	assign byte_class = out_q.byte_class;
	assign frame_end = out_q.frame_end;
	assign frame_ok = out_q.frame_ok;
	assign token_count = out_q.token_count;

endmodule
